/* rtl/core/lcfp_pkg.sv */
// Shared types and constants of the length/checksum frame parser.
package lcfp_pkg;

  localparam int PAYLOAD_DEPTH = 20;
  localparam int IDX_W         = $clog2(PAYLOAD_DEPTH);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W = 8;

  localparam logic [7:0] START_RST = 8'hAA;
  localparam logic [7:0] END_RST   = 8'hBB;
  localparam logic [7:0] LEN_MIN   = 8'd2;
  localparam logic [7:0] LEN_MAX   = 8'(PAYLOAD_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_END   = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    K_PAYLOAD = 3'd0,
    K_OK      = 3'd1,
    K_SUMERR  = 3'd2,
    K_ENDERR  = 3'd3,
    K_BADLEN  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_DATA,
    PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT,
    BK_STAT
  } bk_state_t;

  // One closed frame: its status and, for a good frame, the payload count.
  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] count;
  } cmd_t;

  // Payload store write from the parser to the drain side.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } wr_t;

endpackage

/* rtl/core/lcfp_front.sv */
// Frame parser: hunts for frames, stores payload bytes and posts one command per frame.
module lcfp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          q_full,
  input  logic                          back_busy,
  output logic                          push,
  output lcfp_pkg::cmd_t                push_cmd,
  output lcfp_pkg::wr_t                 wr
);

  lcfp_pkg::phase_t                phase_r, phase_nxt;
  logic [7:0]                      len_r, len_nxt;
  logic [lcfp_pkg::IDX_W-1:0]      cnt_r, cnt_nxt;
  logic [7:0]                      sum_r, sum_nxt;
  logic                            match_r, match_nxt;
  logic [7:0]                      start_r, end_r;

  logic [7:0] rx;
  logic       fire;
  logic       store_byte;
  logic       bad_len;

  assign rx         = in_tdata;
  assign cfg_ready  = 1'b1;
  assign store_byte = (9'(cnt_r) + 9'd2) < 9'(len_r);
  assign bad_len    = (rx < lcfp_pkg::LEN_MIN) || (rx > lcfp_pkg::LEN_MAX);
  assign fire       = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= lcfp_pkg::START_RST;
      end_r   <= lcfp_pkg::END_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == lcfp_pkg::REG_START) begin
        start_r <= cfg_data;
      end else if (cfg_index == lcfp_pkg::REG_END) begin
        end_r <= cfg_data;
      end
    end
  end

  // Output logic: ready, command push and payload store write.
  always_comb begin
    in_tready = 1'b1;
    push      = 1'b0;
    push_cmd  = '{kind: lcfp_pkg::K_BADLEN, count: '0};
    wr        = '{en: 1'b0, addr: cnt_r, data: rx};
    case (phase_r)
      lcfp_pkg::PH_HUNT: begin
        in_tready = 1'b1;
      end
      lcfp_pkg::PH_LEN: begin
        in_tready = !q_full;
        push      = fire && bad_len;
      end
      lcfp_pkg::PH_DATA: begin
        // Payload bytes wait until the previous frame has left the store.
        in_tready = store_byte ? !back_busy : 1'b1;
        wr.en     = fire && store_byte;
      end
      lcfp_pkg::PH_TAIL: begin
        in_tready      = !q_full;
        push           = fire;
        push_cmd.count = cnt_r;
        if (rx != end_r) begin
          push_cmd.kind = lcfp_pkg::K_ENDERR;
        end else if (!match_r) begin
          push_cmd.kind = lcfp_pkg::K_SUMERR;
        end else begin
          push_cmd.kind = lcfp_pkg::K_OK;
        end
      end
      default: begin
        in_tready = 1'b1;
      end
    endcase
  end

  // Next state and frame bookkeeping.
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    match_nxt = match_r;
    if (fire) begin
      case (phase_r)
        lcfp_pkg::PH_HUNT: begin
          if (rx == start_r) begin
            phase_nxt = lcfp_pkg::PH_LEN;
          end
        end
        lcfp_pkg::PH_LEN: begin
          if (bad_len) begin
            phase_nxt = lcfp_pkg::PH_HUNT;
          end else begin
            len_nxt   = rx;
            cnt_nxt   = '0;
            sum_nxt   = '0;
            match_nxt = 1'b0;
            phase_nxt = lcfp_pkg::PH_DATA;
          end
        end
        lcfp_pkg::PH_DATA: begin
          if (store_byte) begin
            sum_nxt = sum_r + rx;
            cnt_nxt = cnt_r + lcfp_pkg::IDX_W'(1);
          end else begin
            match_nxt = (rx == sum_r);
            phase_nxt = lcfp_pkg::PH_TAIL;
          end
        end
        lcfp_pkg::PH_TAIL: begin
          phase_nxt = lcfp_pkg::PH_HUNT;
        end
        default: begin
          phase_nxt = lcfp_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lcfp_pkg::PH_HUNT;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      match_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      match_r <= match_nxt;
    end
  end

  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (32'(wr.addr) < lcfp_pkg::PAYLOAD_DEPTH))
    else $error("payload write beyond store depth");

  a_store_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !back_busy)
    else $error("payload write while drain side busy");

  a_push_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (phase_r == lcfp_pkg::PH_HUNT))
    else $error("command posted without returning to hunt");

endmodule

/* rtl/core/lcfp_queue.sv */
// Short command queue between the parser and the drain side.
module lcfp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lcfp_pkg::cmd_t push_cmd,
  input  logic           pop,
  output lcfp_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);

  lcfp_pkg::cmd_t                entry_r [lcfp_pkg::Q_DEPTH];
  logic [lcfp_pkg::Q_PTR_W-1:0]  wp_r, wp_nxt;
  logic [lcfp_pkg::Q_PTR_W-1:0]  rp_r, rp_nxt;
  logic [lcfp_pkg::Q_CNT_W-1:0]  cnt_r, cnt_nxt;

  localparam logic [lcfp_pkg::Q_PTR_W-1:0] PTR_LAST = lcfp_pkg::Q_PTR_W'(lcfp_pkg::Q_DEPTH - 1);
  localparam logic [lcfp_pkg::Q_CNT_W-1:0] CNT_FULL = lcfp_pkg::Q_CNT_W'(lcfp_pkg::Q_DEPTH);

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_FULL);
  assign head  = entry_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + lcfp_pkg::Q_PTR_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + lcfp_pkg::Q_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + lcfp_pkg::Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - lcfp_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command queue underflow");

endmodule

/* rtl/core/lcfp_back.sv */
// Drain side: holds the payload store and turns commands into result transfers.
module lcfp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lcfp_pkg::wr_t  wr,
  input  logic           q_empty,
  input  lcfp_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           busy,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic [2:0]     out_tuser,
  output logic           out_tlast
);

  lcfp_pkg::bk_state_t         state_r, state_nxt;
  logic [lcfp_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [lcfp_pkg::IDX_W-1:0]  count_r, count_nxt;

  logic [7:0] mem [lcfp_pkg::PAYLOAD_DEPTH];
  logic [7:0] rd_data_r;

  logic            out_valid_r, out_valid_nxt;
  lcfp_pkg::kind_t out_kind_r, out_kind_nxt;
  logic [7:0]      out_value_r, out_value_nxt;
  logic            out_last_r, out_last_nxt;

  logic out_free;
  logic has_payload;
  logic load;

  assign out_free    = !out_valid_r || out_tready;
  assign has_payload = (q_cmd.kind == lcfp_pkg::K_OK) && (q_cmd.count != '0);
  assign busy        = (state_r != lcfp_pkg::BK_IDLE) || !q_empty;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[idx_r];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcfp_pkg::BK_IDLE: begin
        if (!q_empty && out_free && has_payload) begin
          state_nxt = lcfp_pkg::BK_READ;
        end
      end
      lcfp_pkg::BK_READ: begin
        state_nxt = lcfp_pkg::BK_EMIT;
      end
      lcfp_pkg::BK_EMIT: begin
        if (out_free) begin
          state_nxt = (idx_r == count_r - lcfp_pkg::IDX_W'(1)) ?
                      lcfp_pkg::BK_STAT : lcfp_pkg::BK_READ;
        end
      end
      lcfp_pkg::BK_STAT: begin
        if (out_free) begin
          state_nxt = lcfp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = lcfp_pkg::BK_IDLE;
      end
    endcase
  end

  // Outputs: queue pop, read index and output register load.
  always_comb begin
    q_pop         = 1'b0;
    load          = 1'b0;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      lcfp_pkg::BK_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (has_payload) begin
            idx_nxt   = '0;
            count_nxt = q_cmd.count;
          end else begin
            load          = 1'b1;
            out_kind_nxt  = q_cmd.kind;
            out_value_nxt = '0;
            out_last_nxt  = 1'b1;
          end
        end
      end
      lcfp_pkg::BK_READ: begin
        load = 1'b0;
      end
      lcfp_pkg::BK_EMIT: begin
        if (out_free) begin
          load          = 1'b1;
          out_kind_nxt  = lcfp_pkg::K_PAYLOAD;
          out_value_nxt = rd_data_r;
          out_last_nxt  = 1'b0;
          idx_nxt       = idx_r + lcfp_pkg::IDX_W'(1);
        end
      end
      lcfp_pkg::BK_STAT: begin
        if (out_free) begin
          load          = 1'b1;
          out_kind_nxt  = lcfp_pkg::K_OK;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcfp_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    count_r     <= count_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lcfp_pkg::BK_EMIT) |-> (idx_r < count_r))
    else $error("payload read past frame length");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != lcfp_pkg::K_PAYLOAD) |-> (out_last_r && out_value_r == 8'd0))
    else $error("status transfer without last or with nonzero value");

  a_payload_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == lcfp_pkg::K_PAYLOAD) |-> !out_last_r)
    else $error("payload transfer marked last");

  a_no_write_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == lcfp_pkg::BK_IDLE && q_empty))
    else $error("payload store written while a frame drains");

endmodule

/* rtl/core/length_checksum_frame_parser.sv */
// Top level of the length-prefixed frame parser with an additive checksum.
//
// The in_ channel carries one received byte per transfer. The parser hunts for
// the start byte, takes a length byte L and then L-1 data bytes, the last of
// which is the sum of the payload bytes modulo 256; one closing byte follows.
// The out_ channel carries results: payload bytes (tuser kind 0) and one
// status per frame (frame ok, checksum error, end byte error, bad length)
// with tlast high. The cfg_ channel writes the start byte (index 0) and the
// end byte (index 1); cfg_ready is always high.
// A byte is taken every cycle while parsing, unless the queue or store stalls.
// The drain side alternates a store read with an output load, as the store
// read is registered; a good frame also takes its command and ends with its
// status. A status result passes the queue entry and the output register after
// its closing byte; a first payload byte also passes the store read register.
// Payload bytes of the next frame are held off until the store has drained,
// and a length or closing byte waits while the two-entry command queue is full.
// Synchronous reset returns to hunting, restores the default start and end
// bytes and empties the queue and output register; no clearing pass is needed.
// A receiver that holds out_tready low keeps the current result in the output
// register; the parser goes on taking bytes until the queue or store stalls it.
module length_checksum_frame_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,    // [7:0] rx_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,   // [7:0] value
  output logic [2:0]                     out_tuser,   // [2:0] kind
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lcfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           push;
  logic           back_busy;
  lcfp_pkg::cmd_t push_cmd;
  lcfp_pkg::cmd_t q_head;
  lcfp_pkg::wr_t  wr;

  lcfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .back_busy (back_busy),
    .push      (push),
    .push_cmd  (push_cmd),
    .wr        (wr)
  );

  lcfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  lcfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .q_empty    (q_empty),
    .q_cmd      (q_head),
    .q_pop      (q_pop),
    .busy       (back_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
